/* hw/rtl/ragdd_pkg.sv */
// ---------------------------------------------------------------------------
// Deadlock detector package
// Shared types, operation codes and controller-to-datapath command and status
// structures for the resource allocation graph deadlock detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ragdd_pkg;

  localparam int DEF_NUM_PROCS = 8;
  localparam int DEF_NUM_NODES = 16;

  localparam int OP_W     = 2;
  localparam int PID_W    = 3;
  localparam int LOCK_W   = 3;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 8;
  localparam int RANGE_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_DEALLOC = 2'd2,
    OP_DETECT  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_UPD_RD2,
    ST_UPD_WR2,
    ST_ROOT,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_LD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_row;
    logic upd_read;
    logic upd_write;
    logic upd_second;
    logic root_skip;
    logic root_push;
    logic scan;
    logic pop_read;
    logic pop_load;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic is_detect;
    logic two_pass;
    logic root_end;
    logic root_done;
    logic scan_end;
    logic last_level;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ragdd_ctrl.sv */
// ---------------------------------------------------------------------------
// Deadlock detector controller
// Sequences the reset clearing pass, graph updates and the depth-first search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ragdd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ragdd_pkg::dp_sts_t sts,
  output ragdd_pkg::dp_cmd_t cmd
);
  import ragdd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          priority if (sts.is_detect) begin
            state_next = ST_ROOT;
          end else if (sts.in_range) begin
            state_next = ST_UPD_RD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_UPD_RD: begin
        cmd.upd_read = 1'b1;
        state_next   = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_write = 1'b1;
        state_next    = sts.two_pass ? ST_UPD_RD2 : ST_FINISH;
      end
      ST_UPD_RD2: begin
        cmd.upd_read   = 1'b1;
        cmd.upd_second = 1'b1;
        state_next     = ST_UPD_WR2;
      end
      ST_UPD_WR2: begin
        cmd.upd_write  = 1'b1;
        cmd.upd_second = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_ROOT: begin
        priority if (sts.root_end) begin
          state_next = ST_FINISH;
        end else if (sts.root_done) begin
          cmd.root_skip = 1'b1;
        end else begin
          cmd.root_push = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = sts.last_level ? ST_ROOT : ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        cmd.pop_read = 1'b1;
        state_next   = ST_POP_LD;
      end
      ST_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ragdd_datapath.sv */
// ---------------------------------------------------------------------------
// Deadlock detector datapath
// Adjacency memory, search stack memory, node marks, scan registers and the
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ragdd_datapath #(
  parameter int NUM_PROCS = ragdd_pkg::DEF_NUM_PROCS,
  parameter int NUM_NODES = ragdd_pkg::DEF_NUM_NODES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ragdd_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [ragdd_pkg::OP_W-1:0]       s_tuser,
  input  ragdd_pkg::dp_cmd_t               cmd,
  output ragdd_pkg::dp_sts_t               sts,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ragdd_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                             m_tuser
);
  import ragdd_pkg::*;

  localparam int NW = $clog2(NUM_NODES);
  localparam int CW = $clog2(NUM_NODES + 1);

  logic [NUM_NODES-1:0] adj_mem [NUM_NODES];
  logic [NUM_NODES-1:0] adj_rd;
  logic [NW-1:0]        stk_node_mem [NUM_NODES];
  logic [CW-1:0]        stk_next_mem [NUM_NODES];
  logic [NW-1:0]        stk_rd_node;
  logic [CW-1:0]        stk_rd_next;

  op_t                  op_q;
  logic [PID_W-1:0]     pid_q;
  logic [LOCK_W-1:0]    lock_q;
  logic [NW-1:0]        clr_cnt;
  logic [NUM_NODES-1:0] done_marks;
  logic [NUM_NODES-1:0] on_path;
  logic [CW-1:0]        root;
  logic [NW-1:0]        cur_node;
  logic [CW-1:0]        cur_next;
  logic [CW-1:0]        depth;
  logic                 found;
  logic                 deadlock;
  logic                 was_detect;

  logic [RANGE_W-1:0]   in_lnode;
  logic [RANGE_W-1:0]   q_lnode;
  logic [NW-1:0]        pid_node;
  logic [NW-1:0]        lock_node;
  logic [NW-1:0]        upd_row;
  logic [NW-1:0]        upd_bit;
  logic                 upd_set;
  logic [NUM_NODES-1:0] upd_data;
  logic [NW-1:0]        nb;
  logic                 nb_hit;
  logic                 do_push;
  logic                 adj_ren;
  logic [NW-1:0]        adj_raddr;
  logic                 adj_wen;
  logic [NW-1:0]        adj_waddr;
  logic [NUM_NODES-1:0] adj_wdata;
  logic [NW-1:0]        stk_addr;

  assign in_lnode  = RANGE_W'(NUM_PROCS) + RANGE_W'(s_tdata[PID_W +: LOCK_W]);
  assign q_lnode   = RANGE_W'(NUM_PROCS) + RANGE_W'(lock_q);
  assign pid_node  = NW'(pid_q);
  assign lock_node = q_lnode[NW-1:0];

  always_comb begin
    if (cmd.upd_second) begin
      upd_row = pid_node;
      upd_bit = lock_node;
      upd_set = 1'b0;
    end else if (op_q == OP_REQUEST) begin
      upd_row = pid_node;
      upd_bit = lock_node;
      upd_set = 1'b1;
    end else begin
      upd_row = lock_node;
      upd_bit = pid_node;
      upd_set = (op_q == OP_ALLOC);
    end
    upd_data          = adj_rd;
    upd_data[upd_bit] = upd_set;
  end

  assign nb       = cur_next[NW-1:0];
  assign stk_addr = NW'(depth - CW'(1));
  assign nb_hit   = (cur_next != CW'(NUM_NODES)) && adj_rd[nb];
  assign do_push  = cmd.scan && nb_hit && !on_path[nb] && !done_marks[nb] &&
                    (depth < CW'(NUM_NODES));

  always_comb begin
    adj_ren   = 1'b0;
    adj_raddr = upd_row;
    if (cmd.upd_read) begin
      adj_ren = 1'b1;
    end else if (cmd.root_push) begin
      adj_ren   = 1'b1;
      adj_raddr = root[NW-1:0];
    end else if (do_push) begin
      adj_ren   = 1'b1;
      adj_raddr = nb;
    end else if (cmd.pop_load) begin
      adj_ren   = 1'b1;
      adj_raddr = stk_rd_node;
    end
    adj_wen   = cmd.clear_row || cmd.upd_write;
    adj_waddr = cmd.clear_row ? clr_cnt : upd_row;
    adj_wdata = cmd.clear_row ? '0 : upd_data;
  end

  always_ff @(posedge clk) begin
    if (adj_wen) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_ren) begin
      adj_rd <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_node_mem[stk_addr] <= cur_node;
      stk_next_mem[stk_addr] <= cur_next + CW'(1);
    end
    if (cmd.pop_read) begin
      stk_rd_node <= stk_node_mem[stk_addr];
      stk_rd_next <= stk_next_mem[stk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(s_tuser);
      pid_q  <= s_tdata[PID_W-1:0];
      lock_q <= s_tdata[PID_W +: LOCK_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      done_marks <= '0;
      on_path    <= '0;
      root       <= '0;
      cur_node   <= '0;
      cur_next   <= '0;
      depth      <= '0;
      found      <= 1'b0;
    end else begin
      if (cmd.clear_row) begin
        clr_cnt <= clr_cnt + NW'(1);
      end
      if (cmd.capture) begin
        done_marks <= '0;
        on_path    <= '0;
        root       <= '0;
        depth      <= '0;
        found      <= 1'b0;
      end
      if (cmd.root_skip) begin
        root <= root + CW'(1);
      end
      if (cmd.root_push) begin
        cur_node              <= root[NW-1:0];
        cur_next              <= '0;
        on_path[root[NW-1:0]] <= 1'b1;
        depth                 <= CW'(1);
      end
      if (cmd.scan) begin
        if (cur_next == CW'(NUM_NODES)) begin
          on_path[cur_node]    <= 1'b0;
          done_marks[cur_node] <= 1'b1;
          depth                <= depth - CW'(1);
        end else if (do_push) begin
          cur_node    <= nb;
          cur_next    <= '0;
          on_path[nb] <= 1'b1;
          depth       <= depth + CW'(1);
        end else begin
          if (nb_hit && on_path[nb]) begin
            found <= 1'b1;
          end
          cur_next <= cur_next + CW'(1);
        end
      end
      if (cmd.pop_load) begin
        cur_node <= stk_rd_node;
        cur_next <= stk_rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      deadlock   <= found && (op_q == OP_DETECT);
      was_detect <= (op_q == OP_DETECT);
    end
  end

  assign m_tdata = {{(M_DATA_W - 1){1'b0}}, deadlock};
  assign m_tuser = was_detect;

  assign sts.clear_last = (clr_cnt == NW'(NUM_NODES - 1));
  assign sts.in_range   = (RANGE_W'(s_tdata[PID_W-1:0]) < RANGE_W'(NUM_PROCS)) &&
                          (in_lnode < RANGE_W'(NUM_NODES));
  assign sts.is_detect  = (op_t'(s_tuser) == OP_DETECT);
  assign sts.two_pass   = (op_q == OP_ALLOC);
  assign sts.root_end   = (root == CW'(NUM_NODES));
  assign sts.root_done  = done_marks[root[NW-1:0]];
  assign sts.scan_end   = (cur_next == CW'(NUM_NODES));
  assign sts.last_level = (depth == CW'(1));
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

/* hw/rtl/rag_deadlock_detector_unit.sv */
// ---------------------------------------------------------------------------
// Resource allocation graph deadlock detector
// Keeps a process/lock graph as an adjacency bit matrix and searches it for
// cycles on request.
//
//   Port group   Direction  Transfer contents
//   s_*          in         tuser: op [1:0]; tdata: pid [2:0], lock_id [5:3]
//   m_*          out        tdata: deadlock [0]; tuser: was_detect [0]
//
// A request or deallocate updates one row of the graph, an allocate two, and
// an out-of-range update none; each updated row is a read and then a write of
// the adjacency memory. A detect steps through the root indices, starts a
// depth-first search at each one not yet done, scans each row it visits entry
// by entry, and reads and reloads a stack entry on each pop. After reset a
// clearing pass zeroes the adjacency memory row by row with s_tready low. One
// result waits in the output register while the next transfer is taken; a
// stalled result holds the block before its next result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rag_deadlock_detector_unit #(
  parameter int NUM_PROCS = ragdd_pkg::DEF_NUM_PROCS,
  parameter int NUM_NODES = ragdd_pkg::DEF_NUM_NODES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0 up: pid, lock_id.
  input  logic [ragdd_pkg::S_DATA_W-1:0] s_tdata,
  // Fields from bit 0 up: op.
  input  logic [ragdd_pkg::OP_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0 up: deadlock.
  output logic [ragdd_pkg::M_DATA_W-1:0] m_tdata,
  // Fields from bit 0 up: was_detect.
  output logic                           m_tuser
);
  import ragdd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ragdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ragdd_datapath #(
    .NUM_PROCS (NUM_PROCS),
    .NUM_NODES (NUM_NODES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_one_item_at_a_time: assert property (
    @(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready
  ) else $error("Input accepted while a transfer is still in progress.");

  a_result_from_finish: assert property (
    @(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(cmd.finish)
  ) else $error("Result raised without a finish command.");

  a_deadlock_only_detect: assert property (
    @(posedge clk) disable iff (rst) (m_tvalid && m_tdata[0]) |-> m_tuser
  ) else $error("Deadlock flagged on a graph update result.");

  a_scan_exclusive: assert property (
    @(posedge clk) disable iff (rst) cmd.scan |-> !(cmd.upd_write || cmd.clear_row)
  ) else $error("Adjacency write during the search.");

endmodule

`default_nettype wire

/* verif/rag_deadlock_detector_unit_test.sv */
// ---------------------------------------------------------------------------
// Deadlock detector unit test
// Drives graph updates and detect requests through the input stream and
// checks every result against a cycle-search predictor that keeps its own
// copy of the resource allocation graph. Directed graphs come first, then
// random build-and-detect sequences, noise and back-pressure phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rag_deadlock_detector_unit_test;
  import ragdd_pkg::*;

  localparam int PROCS       = DEF_NUM_PROCS;
  localparam int NODES       = DEF_NUM_NODES;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_WAIT = 400;

  typedef struct {
    logic deadlock;
    logic was_detect;
  } verdict_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [OP_W-1:0]     s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  logic [NODES-1:0] graph_rows [NODES];
  verdict_t         pending_verdicts [$];

  int  cycle_count;
  int  mismatch_count;
  int  items_sent;
  int  detects_sent;
  int  cycles_found;
  int  results_seen;
  int  hold_request;
  int  hold_left;
  int  stall_left;
  bit  src_idle_en;
  bit  sink_idle_en;

  rag_deadlock_detector_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_verdicts.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic graph_has_cycle();
    logic [NODES-1:0] done_m;
    logic [NODES-1:0] path_m;
    int               stk_node [NODES];
    int               stk_next [NODES];
    int               depth;
    int               top;
    int               node;
    int               nb;
    int               root;
    int               i;
    logic             found;
    found  = 1'b0;
    done_m = '0;
    path_m = '0;
    for (root = 0; root < NODES; root++) begin
      if (!done_m[root]) begin
        stk_node[0] = root;
        stk_next[0] = 0;
        path_m[root] = 1'b1;
        depth = 1;
        while (depth > 0) begin
          top  = depth - 1;
          node = stk_node[top];
          nb   = NODES;
          for (i = stk_next[top]; i < NODES && nb == NODES; i++)
            if (graph_rows[node][i]) nb = i;
          if (nb >= NODES) begin
            path_m[node] = 1'b0;
            done_m[node] = 1'b1;
            depth--;
          end else begin
            stk_next[top] = nb + 1;
            if (path_m[nb]) begin
              found = 1'b1;
            end else if (!done_m[nb] && depth < NODES) begin
              stk_node[depth] = nb;
              stk_next[depth] = 0;
              path_m[nb] = 1'b1;
              depth++;
            end
          end
        end
      end
    end
    return found;
  endfunction

  function automatic verdict_t predict_verdict(op_t op, logic [2:0] pid, logic [2:0] lck);
    verdict_t v;
    int       lnode;
    v.deadlock   = 1'b0;
    v.was_detect = 1'b0;
    lnode = PROCS + lck;
    if (op == OP_DETECT) begin
      v.deadlock   = graph_has_cycle();
      v.was_detect = 1'b1;
    end else if (pid < PROCS && lnode < NODES) begin
      case (op)
        OP_REQUEST: begin
          graph_rows[pid][lnode] = 1'b1;
        end
        OP_ALLOC: begin
          graph_rows[lnode][pid] = 1'b1;
          graph_rows[pid][lnode] = 1'b0;
        end
        default: begin
          graph_rows[lnode][pid] = 1'b0;
        end
      endcase
    end
    return v;
  endfunction

  task automatic send_op(input op_t op, input logic [2:0] pid, input logic [2:0] lck);
    verdict_t v;
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, lck, pid};
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    v = predict_verdict(op, pid, lck);
    pending_verdicts.push_back(v);
    items_sent++;
    if (v.was_detect) detects_sent++;
    if (v.deadlock) cycles_found++;
  endtask

  task automatic send_detect();
    send_op(OP_DETECT, 3'($urandom), 3'($urandom));
  endtask

  task automatic pause_sender();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result at cycle %0d: deadlock %0b was_detect %0b",
                   cycle_count, m_tdata[0], m_tuser);
      end else begin
        v = pending_verdicts.pop_front();
        if (m_tdata[0] !== v.deadlock || m_tuser !== v.was_detect) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch on result %0d: expected deadlock %0b was_detect %0b, got %0b %0b",
                     results_seen, v.deadlock, v.was_detect, m_tdata[0], m_tuser);
        end
      end
    end
  end

  initial begin
    m_tready   = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_tready   = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic clear_graph();
    int p;
    int l;
    for (p = 0; p < PROCS; p++)
      for (l = 0; l < NODES - PROCS; l++)
        if (graph_rows[p][PROCS + l] || graph_rows[PROCS + l][p]) begin
          if (graph_rows[p][PROCS + l]) send_op(OP_ALLOC, 3'(p), 3'(l));
          send_op(OP_DEALLOC, 3'(p), 3'(l));
        end
  endtask

  task automatic run_scenario();
    int         span;
    int         steps;
    int         k;
    int         r;
    logic [2:0] base_p;
    logic [2:0] base_l;
    logic [2:0] p;
    logic [2:0] l;
    clear_graph();
    span   = $urandom_range(2, 4);
    steps  = $urandom_range(3, 10);
    base_p = 3'($urandom);
    base_l = 3'($urandom);
    for (k = 0; k < steps; k++) begin
      p = base_p + 3'($urandom_range(0, span - 1));
      l = base_l + 3'($urandom_range(0, span - 1));
      r = $urandom_range(0, 9);
      if (r < 4) send_op(OP_REQUEST, p, l);
      else if (r < 8) send_op(OP_ALLOC, p, l);
      else if (r < 9) send_op(OP_DEALLOC, p, l);
      else send_detect();
    end
    send_detect();
  endtask

  task automatic test_directed_updates();
    send_detect();
    send_op(OP_REQUEST, 3'd0, 3'd0);
    send_op(OP_REQUEST, 3'd7, 3'd7);
    send_op(OP_REQUEST, 3'd7, 3'd7);
    send_op(OP_ALLOC, 3'd7, 3'd7);
    send_op(OP_DEALLOC, 3'd7, 3'd7);
    send_op(OP_DEALLOC, 3'd7, 3'd7);
    send_op(OP_ALLOC, 3'd0, 3'd0);
    send_op(OP_DEALLOC, 3'd0, 3'd0);
    send_detect();
  endtask

  task automatic test_directed_cycles();
    send_op(OP_ALLOC, 3'd0, 3'd1);
    send_op(OP_REQUEST, 3'd0, 3'd2);
    send_op(OP_ALLOC, 3'd1, 3'd2);
    send_op(OP_REQUEST, 3'd1, 3'd1);
    send_detect();
    send_op(OP_ALLOC, 3'd5, 3'd6);
    send_op(OP_REQUEST, 3'd5, 3'd7);
    send_op(OP_ALLOC, 3'd6, 3'd7);
    send_op(OP_REQUEST, 3'd6, 3'd6);
    send_detect();
    send_op(OP_DEALLOC, 3'd0, 3'd1);
    send_detect();
    send_op(OP_DEALLOC, 3'd6, 3'd7);
    send_detect();
  endtask

  task automatic test_random_scenarios(input int item_goal);
    while (items_sent < item_goal) run_scenario();
  endtask

  task automatic test_random_noise(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 6) == 0) send_detect();
      else send_op(op_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_long_hold();
    int k;
    pause_sender();
    src_idle_en  = 1'b0;
    hold_request = 300;
    @(negedge clk);
    for (k = 0; k < 40; k++) begin
      if (k % 8 == 7) send_detect();
      else send_op(op_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom));
    end
    src_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    int k;
    for (k = 0; k < 4; k++) begin
      run_scenario();
      pause_sender();
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cycle_count  = 0;
    hold_request = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int n = 0; n < NODES; n++) graph_rows[n] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_updates();
    test_directed_cycles();
    test_random_scenarios(1300);
    test_random_noise(300);
    test_long_hold();
    test_drain_pause();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_scenarios(1900);

    pause_sender();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("Sent %0d transfers, %0d of them detects, %0d of which found a cycle.",
             items_sent, detects_sent, cycles_found);
    $display("Checked %0d results in %0d cycles with %0d mismatches.",
             results_seen, cycle_count, mismatch_count);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
